/* sv/mjtt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjtt_pkg: shared definitions for the joint TLB translate block
// Field widths, request and fault codes, and EntryLo layout constants.
// ----------------------------------------------------------------------------
package mjtt_pkg;

   localparam int TLB_ENTRIES_DEFAULT = 128;

   localparam int REQ_W    = 3;
   localparam int ADDR_W   = 32;
   localparam int VPN2_W   = 19;
   localparam int ASID_W   = 8;
   localparam int LO_W     = 30;
   localparam int PIDX_W   = 7;
   localparam int FAULT_W  = 3;
   localparam int LFSR_W   = 7;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 7'd1;

   localparam int PAGE_BITS  = 12;
   localparam int LO_V_BIT   = 1;
   localparam int PFN_LSB    = 6;
   // physical page bits that survive truncation to 32 bits with bit 31 cleared
   localparam int PFN_KEEP_W = ADDR_W - 1 - PAGE_BITS;

   typedef enum logic [REQ_W-1:0] {
      REQ_WRITE_IDX  = 3'd0,
      REQ_WRITE_RAND = 3'd1,
      REQ_PROBE      = 3'd2,
      REQ_LOAD       = 3'd3,
      REQ_STORE      = 3'd4
   } req_kind_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE          = 3'd0,
      FAULT_INVALID_LOAD  = 3'd1,
      FAULT_INVALID_STORE = 3'd2,
      FAULT_REFILL_LOAD   = 3'd3,
      FAULT_REFILL_STORE  = 3'd4
   } fault_kind_type;

endpackage

/* sv/mips_joint_tlb_translate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_joint_tlb_translate: fully associative paired-page TLB
// Indexed and random entry writes, VPN2 probe, and load/store translation.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall with req_type selecting indexed
//   write, random write, probe, load or store translation. Every request
//   returns exactly one response on rsp_valid/rsp_stall; write requests and
//   undefined types answer with all fields zero.
//   A request is registered on acceptance, then resolved by a parallel VPN2
//   compare over all entries and a lowest-index priority encode, and lands
//   in the response register. One request per cycle is sustained while
//   rsp_stall does not hold a valid response; the compare, priority encode
//   and EntryLo select form the cycle's logic.
//   Writes take effect when the request moves to the response register, so
//   a following lookup sees them.
//   Reset clears all entries to zero (valid bits clear) and seeds the random
//   index generator with 1; no clearing pass is needed.
//   While rsp_stall holds a valid response, the response and the request
//   behind it hold and req_stall rises once that request is waiting.
// ----------------------------------------------------------------------------
module mips_joint_tlb_translate #(
   parameter int TLB_ENTRIES = mjtt_pkg::TLB_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mjtt_pkg::REQ_W-1:0]   req_type,
   input  logic [mjtt_pkg::ADDR_W-1:0]  req_vaddr,
   input  logic [mjtt_pkg::VPN2_W-1:0]  req_hi_vpn2,
   input  logic [mjtt_pkg::ASID_W-1:0]  req_hi_asid,
   input  logic [mjtt_pkg::LO_W-1:0]    req_lo_even,
   input  logic [mjtt_pkg::LO_W-1:0]    req_lo_odd,
   input  logic [mjtt_pkg::PIDX_W-1:0]  req_write_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mjtt_pkg::ADDR_W-1:0]  rsp_paddr,
   output logic                         rsp_probe_found,
   output logic [mjtt_pkg::PIDX_W-1:0]  rsp_probe_index,
   output logic [mjtt_pkg::FAULT_W-1:0] rsp_fault,
   output logic [mjtt_pkg::VPN2_W-1:0]  rsp_fault_vpn2
);
   import mjtt_pkg::*;

   localparam int IDX_W   = $clog2(TLB_ENTRIES);
   localparam int WIDX_N  = 2 ** PIDX_W;

   logic              a_valid_ff, a_valid_in;
   logic [REQ_W-1:0]  a_type_ff;
   logic [ADDR_W-1:0] a_vaddr_ff;
   logic [VPN2_W-1:0] a_vpn2_ff;
   logic [ASID_W-1:0] a_asid_ff;
   logic [LO_W-1:0]   a_lo_even_ff;
   logic [LO_W-1:0]   a_lo_odd_ff;
   logic [PIDX_W-1:0] a_widx_ff;

   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  paddr_ff, paddr_in;
   logic               found_ff, found_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic [VPN2_W-1:0]  fvpn2_ff, fvpn2_in;

   logic                   advance;
   logic                   accept;
   logic                   fire;
   logic [IDX_W-1:0]       mod_tbl [WIDX_N];
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [VPN2_W-1:0]      key;
   logic [VPN2_W-1:0]      va_vpn2;
   logic [TLB_ENTRIES-1:0] match;
   logic [TLB_ENTRIES-1:0] first;
   logic                   hit;
   logic [IDX_W-1:0]       hit_idx;
   logic [LO_W-1:0]        sel_lo_even;
   logic [LO_W-1:0]        sel_lo_odd;
   logic [LO_W-1:0]        lo;

   for (genvar g = 0; g < WIDX_N; g++) begin : g_mod
      assign mod_tbl[g] = IDX_W'(g % TLB_ENTRIES);
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign fire      = a_valid_ff && advance;
   assign a_valid_in = req_stall ? a_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_type_ff    <= '0;
         a_vaddr_ff   <= '0;
         a_vpn2_ff    <= '0;
         a_asid_ff    <= '0;
         a_lo_even_ff <= '0;
         a_lo_odd_ff  <= '0;
         a_widx_ff    <= '0;
      end else if (accept) begin
         a_type_ff    <= req_type;
         a_vaddr_ff   <= req_vaddr;
         a_vpn2_ff    <= req_hi_vpn2;
         a_asid_ff    <= req_hi_asid;
         a_lo_even_ff <= req_lo_even;
         a_lo_odd_ff  <= req_lo_odd;
         a_widx_ff    <= req_write_index;
      end
   end

   assign va_vpn2 = a_vaddr_ff[ADDR_W-1 -: VPN2_W];
   assign key     = (a_type_ff == REQ_PROBE) ? a_vpn2_ff : va_vpn2;
   assign wr_en   = fire && (a_type_ff == REQ_WRITE_IDX || a_type_ff == REQ_WRITE_RAND);
   assign wr_idx  = (a_type_ff == REQ_WRITE_RAND) ? mod_tbl[lfsr_ff] : mod_tbl[a_widx_ff];

   mjtt_entries #(
      .ENTRIES (TLB_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_entries (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_vpn2     (a_vpn2_ff),
      .wr_asid     (a_asid_ff),
      .wr_lo_even  (a_lo_even_ff),
      .wr_lo_odd   (a_lo_odd_ff),
      .key         (key),
      .match       (match),
      .sel         (first),
      .sel_lo_even (sel_lo_even),
      .sel_lo_odd  (sel_lo_odd)
   );

   mjtt_prio #(
      .ENTRIES (TLB_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_prio (
      .clock (clock),
      .reset (reset),
      .match (match),
      .first (first),
      .found (hit),
      .index (hit_idx)
   );

   assign lo = a_vaddr_ff[PAGE_BITS] ? sel_lo_odd : sel_lo_even;

   always_comb begin
      lfsr_in = lfsr_ff;
      if (fire && a_type_ff == REQ_WRITE_RAND) begin
         lfsr_in = {lfsr_ff[LFSR_W-2:0], lfsr_ff[LFSR_W-1] ^ lfsr_ff[LFSR_W-2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_comb begin
      logic is_store;
      is_store = (a_type_ff == REQ_STORE);
      paddr_in = '0;
      found_in = 1'b0;
      pidx_in  = '0;
      fault_in = FAULT_NONE;
      fvpn2_in = '0;
      unique case (a_type_ff)
         REQ_PROBE: begin
            found_in = hit;
            pidx_in  = hit ? PIDX_W'(hit_idx) : '0;
         end
         REQ_LOAD, REQ_STORE: begin
            priority if (a_vaddr_ff[31] && a_vaddr_ff[29]) begin
               paddr_in = {1'b0, a_vaddr_ff[30], 1'b0, a_vaddr_ff[28:0]};
            end else if (a_vaddr_ff[31]) begin
               paddr_in = {1'b0, a_vaddr_ff[30:0]};
            end else if (!hit) begin
               fault_in = is_store ? FAULT_REFILL_STORE : FAULT_REFILL_LOAD;
               fvpn2_in = va_vpn2;
            end else if (!lo[LO_V_BIT]) begin
               fault_in = is_store ? FAULT_INVALID_STORE : FAULT_INVALID_LOAD;
               fvpn2_in = va_vpn2;
            end else begin
               paddr_in = {1'b0, lo[PFN_LSB +: PFN_KEEP_W], a_vaddr_ff[PAGE_BITS-1:0]};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = advance ? a_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         paddr_ff <= paddr_in;
         found_ff <= found_in;
         pidx_ff  <= pidx_in;
         fault_ff <= fault_in;
         fvpn2_ff <= fvpn2_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_paddr       = paddr_ff;
   assign rsp_probe_found = found_ff;
   assign rsp_probe_index = pidx_ff;
   assign rsp_fault       = fault_ff;
   assign rsp_fault_vpn2  = fvpn2_ff;

`ifndef SYNTHESIS
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("random index generator reached zero");
   a_fault_no_paddr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fault_ff != FAULT_NONE |-> paddr_ff == '0 && !found_ff)
      else $error("faulted response carries an address or probe hit");
   a_probe_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> pidx_ff == '0)
      else $error("probe miss with nonzero index");
   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !advance |=> a_valid_ff)
      else $error("waiting request dropped");
`endif

endmodule

/* sv/mjtt_entries.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjtt_entries: TLB entry array with per-entry VPN2 compare
// Holds VPN2, ASID and both EntryLo words per entry; an entry never written
// reads as all zero. Gives the match vector and the EntryLo pair of the
// one-hot selected entry.
// ----------------------------------------------------------------------------
module mjtt_entries #(
   parameter int ENTRIES = mjtt_pkg::TLB_ENTRIES_DEFAULT,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [mjtt_pkg::VPN2_W-1:0] wr_vpn2,
   input  logic [mjtt_pkg::ASID_W-1:0] wr_asid,
   input  logic [mjtt_pkg::LO_W-1:0]   wr_lo_even,
   input  logic [mjtt_pkg::LO_W-1:0]   wr_lo_odd,
   input  logic [mjtt_pkg::VPN2_W-1:0] key,
   output logic [ENTRIES-1:0]          match,
   input  logic [ENTRIES-1:0]          sel,
   output logic [mjtt_pkg::LO_W-1:0]   sel_lo_even,
   output logic [mjtt_pkg::LO_W-1:0]   sel_lo_odd
);
   import mjtt_pkg::*;

   logic [VPN2_W-1:0] vpn2_ff    [ENTRIES];
   logic [ASID_W-1:0] asid_ff    [ENTRIES];
   logic [LO_W-1:0]   lo_even_ff [ENTRIES];
   logic [LO_W-1:0]   lo_odd_ff  [ENTRIES];
   logic [ENTRIES-1:0] written_ff;
   logic [ENTRIES-1:0] written_in;

   always_comb begin
      written_in = written_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         if (wr_en && wr_idx == IDX_W'(i)) begin
            written_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (wr_en && wr_idx == IDX_W'(i)) begin
            vpn2_ff[i]    <= wr_vpn2;
            asid_ff[i]    <= wr_asid;
            lo_even_ff[i] <= wr_lo_even;
            lo_odd_ff[i]  <= wr_lo_odd;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = written_ff[i] ? (vpn2_ff[i] == key) : (key == '0);
      end
   end

   always_comb begin
      sel_lo_even = '0;
      sel_lo_odd  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i] && written_ff[i]) begin
            sel_lo_even = sel_lo_even | lo_even_ff[i];
            sel_lo_odd  = sel_lo_odd | lo_odd_ff[i];
         end
      end
   end

   // ASID is kept with the entry but takes no part in the compare
   logic unused_asid;
   always_comb begin
      unused_asid = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         unused_asid = unused_asid ^ (^asid_ff[i]);
      end
   end

`ifndef SYNTHESIS
   a_write_marks_entry: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> written_ff[$past(wr_idx)])
      else $error("written entry not marked");
`endif

endmodule

/* sv/mjtt_prio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjtt_prio: lowest-index priority encoder
// Picks the lowest set bit of the match vector as a one-hot select and index.
// ----------------------------------------------------------------------------
module mjtt_prio #(
   parameter int ENTRIES = mjtt_pkg::TLB_ENTRIES_DEFAULT,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRIES-1:0] match,
   output logic [ENTRIES-1:0] first,
   output logic               found,
   output logic [IDX_W-1:0]   index
);
   import mjtt_pkg::*;

   always_comb begin
      logic seen;
      seen  = 1'b0;
      first = '0;
      index = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         first[i] = match[i] & ~seen;
         seen     = seen | match[i];
         if (first[i]) begin
            index = index | IDX_W'(i);
         end
      end
      found = seen;
   end

`ifndef SYNTHESIS
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first))
      else $error("more than one entry selected");
   a_first_in_match: assert property (@(posedge clock) disable iff (reset)
      (first & ~match) == '0)
      else $error("selected entry does not match");
   a_found_any: assert property (@(posedge clock) disable iff (reset)
      found == (match != '0))
      else $error("found flag disagrees with match vector");
`endif

endmodule

/* sim/mjtt_answer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjtt_answer_checker: response predictor and scoreboard for the joint TLB
// Watches both channels and keeps its own copy of the TLB entries and the
// random index generator. Each accepted request is resolved into the answer
// the block owes. Each accepted response is compared field by field with the
// oldest answer still owed.
// ----------------------------------------------------------------------------
module mjtt_answer_checker #(
   parameter int TLB_ENTRIES = mjtt_pkg::TLB_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [mjtt_pkg::REQ_W-1:0]   req_type,
   input  logic [mjtt_pkg::ADDR_W-1:0]  req_vaddr,
   input  logic [mjtt_pkg::VPN2_W-1:0]  req_hi_vpn2,
   input  logic [mjtt_pkg::ASID_W-1:0]  req_hi_asid,
   input  logic [mjtt_pkg::LO_W-1:0]    req_lo_even,
   input  logic [mjtt_pkg::LO_W-1:0]    req_lo_odd,
   input  logic [mjtt_pkg::PIDX_W-1:0]  req_write_index,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [mjtt_pkg::ADDR_W-1:0]  rsp_paddr,
   input  logic                         rsp_probe_found,
   input  logic [mjtt_pkg::PIDX_W-1:0]  rsp_probe_index,
   input  logic [mjtt_pkg::FAULT_W-1:0] rsp_fault,
   input  logic [mjtt_pkg::VPN2_W-1:0]  rsp_fault_vpn2,
   output int                           mismatch_count,
   output int                           answers_pending
);
   import mjtt_pkg::*;

   localparam logic [ADDR_W-1:0] UNMAPPED_UNCACHED = 32'ha000_0000;
   localparam logic [ADDR_W-1:0] UNMAPPED_CACHED   = 32'h8000_0000;

   typedef struct packed {
      logic [ADDR_W-1:0]  paddr;
      logic               probe_found;
      logic [PIDX_W-1:0]  probe_index;
      logic [FAULT_W-1:0] fault;
      logic [VPN2_W-1:0]  fault_vpn2;
   } tlb_answer_type;

   logic [VPN2_W-1:0] tlb_vpn2    [TLB_ENTRIES];
   logic [ASID_W-1:0] tlb_asid    [TLB_ENTRIES];
   logic [LO_W-1:0]   tlb_lo_even [TLB_ENTRIES];
   logic [LO_W-1:0]   tlb_lo_odd  [TLB_ENTRIES];
   logic [LFSR_W-1:0] rand_index;
   tlb_answer_type    answer_q[$];

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] seen,
                                  input logic [ADDR_W-1:0] wanted);
      $display("%0t tlb response %s: got %h, expected %h", $time, what, seen, wanted);
      mismatch_count++;
   endtask

   task automatic write_entry(input int idx, input logic [VPN2_W-1:0] vpn2,
                              input logic [ASID_W-1:0] asid,
                              input logic [LO_W-1:0] lo_e, input logic [LO_W-1:0] lo_o);
      tlb_vpn2[idx]    = vpn2;
      tlb_asid[idx]    = asid;
      tlb_lo_even[idx] = lo_e;
      tlb_lo_odd[idx]  = lo_o;
   endtask

   function automatic int lowest_match(input logic [VPN2_W-1:0] vpn2);
      int found = -1;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--)
         if (tlb_vpn2[i] == vpn2) found = i;
      return found;
   endfunction

   task automatic resolve_request(input logic [REQ_W-1:0] kind,
                                  input logic [ADDR_W-1:0] va,
                                  input logic [VPN2_W-1:0] vpn2,
                                  input logic [ASID_W-1:0] asid,
                                  input logic [LO_W-1:0] lo_e,
                                  input logic [LO_W-1:0] lo_o,
                                  input logic [PIDX_W-1:0] widx,
                                  output tlb_answer_type ans);
      logic [VPN2_W-1:0] va_vpn2;
      logic [LO_W-1:0]   lo;
      int                hit;
      ans = '0;
      case (kind)
         REQ_WRITE_IDX: write_entry(int'(widx) % TLB_ENTRIES, vpn2, asid, lo_e, lo_o);
         REQ_WRITE_RAND: begin
            write_entry(int'(rand_index) % TLB_ENTRIES, vpn2, asid, lo_e, lo_o);
            rand_index = {rand_index[LFSR_W-2:0],
                          rand_index[LFSR_W-1] ^ rand_index[LFSR_W-2]};
         end
         REQ_PROBE: begin
            hit = lowest_match(vpn2);
            if (hit >= 0) begin
               ans.probe_found = 1'b1;
               ans.probe_index = hit[PIDX_W-1:0];
            end
         end
         REQ_LOAD, REQ_STORE: begin
            if ((va & UNMAPPED_UNCACHED) == UNMAPPED_UNCACHED) begin
               ans.paddr = va & ~UNMAPPED_UNCACHED;
            end else if (va[ADDR_W-1]) begin
               ans.paddr = va & ~UNMAPPED_CACHED;
            end else begin
               va_vpn2 = va[ADDR_W-1 -: VPN2_W];
               hit = lowest_match(va_vpn2);
               if (hit < 0) begin
                  ans.fault = (kind == REQ_STORE) ? FAULT_REFILL_STORE : FAULT_REFILL_LOAD;
                  ans.fault_vpn2 = va_vpn2;
               end else begin
                  lo = va[PAGE_BITS] ? tlb_lo_odd[hit] : tlb_lo_even[hit];
                  if (!lo[LO_V_BIT]) begin
                     ans.fault = (kind == REQ_STORE) ? FAULT_INVALID_STORE
                                                     : FAULT_INVALID_LOAD;
                     ans.fault_vpn2 = va_vpn2;
                  end else begin
                     ans.paddr = {1'b0, lo[PFN_LSB +: PFN_KEEP_W], va[PAGE_BITS-1:0]};
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      tlb_answer_type want;
      if (reset) begin
         for (int i = 0; i < TLB_ENTRIES; i++) write_entry(i, '0, '0, '0, '0);
         rand_index = LFSR_SEED;
         answer_q.delete();
         answers_pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report_mismatch("with no request outstanding, paddr", rsp_paddr, '0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_paddr !== want.paddr)
                  report_mismatch("paddr", rsp_paddr, want.paddr);
               if (rsp_probe_found !== want.probe_found)
                  report_mismatch("probe_found", ADDR_W'(rsp_probe_found),
                                  ADDR_W'(want.probe_found));
               if (rsp_probe_index !== want.probe_index)
                  report_mismatch("probe_index", ADDR_W'(rsp_probe_index),
                                  ADDR_W'(want.probe_index));
               if (rsp_fault !== want.fault)
                  report_mismatch("fault", ADDR_W'(rsp_fault), ADDR_W'(want.fault));
               if (rsp_fault_vpn2 !== want.fault_vpn2)
                  report_mismatch("fault_vpn2", ADDR_W'(rsp_fault_vpn2),
                                  ADDR_W'(want.fault_vpn2));
            end
         end
         if (req_valid && !req_stall) begin
            resolve_request(req_type, req_vaddr, req_hi_vpn2, req_hi_asid,
                            req_lo_even, req_lo_odd, req_write_index, want);
            answer_q.push_back(want);
         end
         answers_pending = answer_q.size();
      end
   end

endmodule

/* sim/tb_mips_joint_tlb_translate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_joint_tlb_translate: stimulus and verdict for the joint TLB
// Drives a directed set of requests over the segment boundaries, faults,
// shadowed entries and undefined types, then random requests drawn mostly
// from a small set of page numbers so that writes, probes and translations
// meet the same entries. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_mips_joint_tlb_translate;
   import mjtt_pkg::*;

   localparam int RANDOM_PER_PHASE = 525;
   localparam int VPN2_POOL        = 16;
   localparam logic [REQ_W-1:0] REQ_UNDEF_FIRST = REQ_W'(REQ_STORE + 1);

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [REQ_W-1:0]   req_type        = '0;
   logic [ADDR_W-1:0]  req_vaddr       = '0;
   logic [VPN2_W-1:0]  req_hi_vpn2     = '0;
   logic [ASID_W-1:0]  req_hi_asid     = '0;
   logic [LO_W-1:0]    req_lo_even     = '0;
   logic [LO_W-1:0]    req_lo_odd      = '0;
   logic [PIDX_W-1:0]  req_write_index = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [ADDR_W-1:0]  rsp_paddr;
   logic               rsp_probe_found;
   logic [PIDX_W-1:0]  rsp_probe_index;
   logic [FAULT_W-1:0] rsp_fault;
   logic [VPN2_W-1:0]  rsp_fault_vpn2;

   int                 mismatch_count;
   int                 answers_pending;
   int                 req_idle_pct    = 0;
   int                 rsp_stall_pct   = 0;
   logic [VPN2_W-1:0]  vpn2_pool [VPN2_POOL];

   mips_joint_tlb_translate uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_vaddr       (req_vaddr),
      .req_hi_vpn2     (req_hi_vpn2),
      .req_hi_asid     (req_hi_asid),
      .req_lo_even     (req_lo_even),
      .req_lo_odd      (req_lo_odd),
      .req_write_index (req_write_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_paddr       (rsp_paddr),
      .rsp_probe_found (rsp_probe_found),
      .rsp_probe_index (rsp_probe_index),
      .rsp_fault       (rsp_fault),
      .rsp_fault_vpn2  (rsp_fault_vpn2)
   );

   mjtt_answer_checker answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_vaddr       (req_vaddr),
      .req_hi_vpn2     (req_hi_vpn2),
      .req_hi_asid     (req_hi_asid),
      .req_lo_even     (req_lo_even),
      .req_lo_odd      (req_lo_odd),
      .req_write_index (req_write_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_paddr       (rsp_paddr),
      .rsp_probe_found (rsp_probe_found),
      .rsp_probe_index (rsp_probe_index),
      .rsp_fault       (rsp_fault),
      .rsp_fault_vpn2  (rsp_fault_vpn2),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   function automatic logic [LO_W-1:0] page_lo(input logic [23:0] pfn, input logic valid);
      return {pfn, 3'($urandom), 1'($urandom), valid, 1'($urandom)};
   endfunction

   task automatic issue_request(input logic [REQ_W-1:0] kind,
                                input logic [ADDR_W-1:0] va,
                                input logic [VPN2_W-1:0] vpn2,
                                input logic [ASID_W-1:0] asid,
                                input logic [LO_W-1:0] lo_e,
                                input logic [LO_W-1:0] lo_o,
                                input logic [PIDX_W-1:0] widx);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_type        <= kind;
      req_vaddr       <= va;
      req_hi_vpn2     <= vpn2;
      req_hi_asid     <= asid;
      req_lo_even     <= lo_e;
      req_lo_odd      <= lo_o;
      req_write_index <= widx;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue_random_request();
      int                pick;
      int                where;
      logic [REQ_W-1:0]  kind;
      logic [VPN2_W-1:0] vpn2;
      logic [ADDR_W-1:0] va;
      pick  = $urandom_range(0, 99);
      where = $urandom_range(0, 19);
      vpn2  = ($urandom_range(0, 3) != 0) ? vpn2_pool[$urandom_range(0, VPN2_POOL - 1)]
                                          : VPN2_W'($urandom);
      if (where < 15)
         va = {vpn2_pool[$urandom_range(0, VPN2_POOL - 1)], (PAGE_BITS + 1)'($urandom)};
      else if (where < 17)
         va = $urandom;
      else
         va = {1'b1, (ADDR_W - 1)'($urandom)};
      if (pick < 14)      kind = REQ_WRITE_IDX;
      else if (pick < 22) kind = REQ_WRITE_RAND;
      else if (pick < 34) kind = REQ_PROBE;
      else if (pick < 64) kind = REQ_LOAD;
      else if (pick < 94) kind = REQ_STORE;
      else                kind = REQ_UNDEF_FIRST + REQ_W'($urandom_range(0, 2));
      issue_request(kind, va, vpn2, ASID_W'($urandom), LO_W'($urandom), LO_W'($urandom),
                    PIDX_W'($urandom));
   endtask

   initial begin
      vpn2_pool[0] = '0;
      for (int i = 1; i < VPN2_POOL; i++) vpn2_pool[i] = {1'b0, (VPN2_W - 1)'($urandom)};
      req_idle_pct  = 27;
      rsp_stall_pct = 47;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset entries all match page zero with valid bits clear
      issue_request(REQ_LOAD, 32'h0000_0000, '0, '0, '0, '0, '0);
      issue_request(REQ_STORE, 32'h0000_1fff, '0, '0, '0, '0, '0);
      issue_request(REQ_PROBE, '0, '0, '0, '0, '0, '0);
      issue_request(REQ_PROBE, '0, '1, '0, '0, '0, '0);
      issue_request(REQ_LOAD, 32'h7fff_ffff, '0, '0, '0, '0, '0);
      issue_request(REQ_STORE, 32'h4000_2000, '0, '0, '0, '0, '0);
      // unmapped segments
      issue_request(REQ_LOAD, 32'hffff_ffff, '0, '0, '0, '0, '0);
      issue_request(REQ_STORE, 32'ha000_0000, '0, '0, '0, '0, '0);
      issue_request(REQ_LOAD, 32'h8000_0000, '0, '0, '0, '0, '0);
      issue_request(REQ_STORE, 32'h9fff_ffff, '0, '0, '0, '0, '0);
      issue_request(REQ_LOAD, 32'hc000_1234, '0, '0, '0, '0, '0);
      // top entry with even page valid, odd page invalid
      issue_request(REQ_WRITE_IDX, '1, 19'h3ffff, '1, '1, '0, '1);
      issue_request(REQ_LOAD, 32'h7fff_efff, '0, '0, '0, '0, '0);
      issue_request(REQ_STORE, 32'h7fff_f123, '0, '0, '0, '0, '0);
      issue_request(REQ_PROBE, '0, 19'h3ffff, '0, '0, '0, '0);
      // random write lands below the top entry and takes priority
      issue_request(REQ_WRITE_RAND, '0, 19'h3ffff, 8'h5a, page_lo(24'h000abc, 1'b1),
                    page_lo(24'hfff000, 1'b1), '0);
      issue_request(REQ_PROBE, '0, 19'h3ffff, '0, '0, '0, '0);
      issue_request(REQ_LOAD, 32'h7fff_f800, '0, '0, '0, '0, '0);
      // invalid low entry shadows a valid higher one
      issue_request(REQ_WRITE_IDX, '0, 19'h5, '0, page_lo(24'h1, 1'b0),
                    page_lo(24'h1, 1'b0), 7'd0);
      issue_request(REQ_WRITE_IDX, '0, 19'h5, '0, page_lo(24'h2, 1'b1),
                    page_lo(24'h2, 1'b1), 7'd2);
      issue_request(REQ_LOAD, 32'h0000_a000, '0, '0, '0, '0, '0);
      // undefined request types
      for (int k = 0; k < 3; k++)
         issue_request(REQ_UNDEF_FIRST + REQ_W'(k), '1, '1, '1, '1, '1, '1);
      issue_request(REQ_WRITE_IDX, '0, '0, '0, '0, '0, 7'd0);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
         rsp_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) issue_random_request();
      end

      // drain
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && answers_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
